// ===== hw/rtl/mma_pkg.sv =====
// package for the multichannel moving average block
// holds sizes, payload structs and the divider control type; no dependencies
`timescale 1ns / 1ps

package mma_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int MAX_WINDOW_DEF = 32;
    localparam int MIN_WINDOW     = 3;
    localparam int CFG_W          = 6;
    localparam int CH_FIELD_W     = 3;
    localparam int SAMPLE_W       = 32;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEP       = 4;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]      channel;
        logic signed [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]      out_channel;
        logic signed [SAMPLE_W-1:0] average;
    } out_t;

    typedef struct packed {
        logic start;
        logic negate;
    } div_ctrl_t;

endpackage

// ===== hw/rtl/mma_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module mma_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/mma_divider.sv =====
// iterative restoring divider, DIV_STEP quotient bits per cycle
// divides a magnitude by the window length and applies the sign; uses mma_pkg
`timescale 1ns / 1ps

module mma_divider #(
    parameter int SUM_W = 37,
    parameter int WIN_W = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mma_pkg::div_ctrl_t               ctrl,
    input  logic [SUM_W-1:0]                 dividend,
    input  logic [WIN_W-1:0]                 divisor,
    output logic                             busy,
    output logic signed [mma_pkg::SAMPLE_W-1:0] quotient
);
    import mma_pkg::*;

    localparam int STEPS = (SUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W = STEPS * DIV_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [WIN_W-1:0] rem_reg, rem_next;
    logic [WIN_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [SAMPLE_W-1:0] q_mag;

    // one radix-16 step as four chained restoring steps
    always_comb begin
        logic [WIN_W:0] trial;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial    = {rem_next, dvd_next[DIV_W-1]};
            dvd_next = {dvd_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next    = WIN_W'(trial - {1'b0, dsr_reg});
                dvd_next[0] = 1'b1;
            end else begin
                rem_next = trial[WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctrl.start) begin
            cnt_reg <= CNT_W'(STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            dvd_reg <= DIV_W'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= ctrl.negate;
        end else if (cnt_reg != '0) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign q_mag    = dvd_reg[SAMPLE_W-1:0];
    assign quotient = neg_reg ? SAMPLE_W'(~q_mag + 1'b1) : q_mag;

endmodule

// ===== hw/rtl/multichannel_moving_average.sv =====
// top level of the multichannel moving average block
// uses mma_pkg, mma_ram (sample and channel-state stores) and mma_divider
`timescale 1ns / 1ps

// Per-channel moving average. Each input transaction carries a channel number and a signed
// Q16.16 sample; the block replaces that channel's oldest stored sample, updates an exact
// running sum and returns one result transaction with the channel and the sum divided by the
// effective window, truncated toward zero. The window is cfg_wr_data written through
// cfg_wr_en, clamped to the range 3..MAX_WINDOW; it resets to 3. Samples start at zero, so
// a channel's first results average in zeros. A channel number at or above CHANNELS leaves
// all state alone and returns an average of zero. After reset and after every window write
// the stores are swept to zero over all CHANNELS*MAX_WINDOW sample slots (256 at the
// defaults), and no input transaction is taken during the sweep. One transaction is
// handled at a time, from acceptance through the channel-state read, the sample read and
// the read-modify-write, then the iterative divider resolving four quotient bits a cycle,
// then the load of the output register, which waits while an earlier result is still
// unaccepted. A result waiting in the output register does not hold off the next input
// transaction.

module multichannel_moving_average #(
    parameter int CHANNELS   = mma_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW = mma_pkg::MAX_WINDOW_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mma_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mma_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mma_pkg::out_t               m_data
);
    import mma_pkg::*;

    // exact sum, window and pointer widths
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CST_W  = SUM_W + POS_W;

    // sequencer codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHAN  = 3'd2;
    localparam logic [2:0] S_SAMP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CFG_W-1:0]        window_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;

    // the transaction in flight
    logic [CH_FIELD_W-1:0]   chan_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                    in_range_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [POS_W-1:0]        pos_next_reg;
    logic [ADDR_W-1:0]       addr_reg;

    // output register
    logic                    m_valid_reg;
    out_t                    m_data_reg;

    logic [WIN_W-1:0]        win_eff;
    logic                    in_range;
    logic [CH_W-1:0]         ch_idx;

    // channel-state store: {running sum, write position}
    logic                    cst_we;
    logic [CH_W-1:0]         cst_waddr, cst_raddr;
    logic [CST_W-1:0]        cst_wdata, cst_rdata;

    // sample store, channel-major, MAX_WINDOW slots per channel
    logic                    smp_we;
    logic [ADDR_W-1:0]       smp_waddr, smp_raddr;
    logic [SAMPLE_W-1:0]     smp_wdata, smp_rdata;

    logic [POS_W-1:0]        pos_old, pos_cur;
    logic [WIN_W-1:0]        pos_inc;
    logic [POS_W-1:0]        pos_wrap;
    logic signed [SUM_W-1:0] new_sum;
    logic [SUM_W-1:0]        sum_mag;

    div_ctrl_t               div_ctrl;
    logic                    div_busy;
    logic signed [SAMPLE_W-1:0] div_q;

    // effective window, clamped both ways
    always_comb begin
        if (int'(window_reg) < MIN_WINDOW) begin
            win_eff = WIN_W'(MIN_WINDOW);
        end else if (int'(window_reg) > MAX_WINDOW) begin
            win_eff = WIN_W'(MAX_WINDOW);
        end else begin
            win_eff = WIN_W'(window_reg);
        end
    end

    assign in_range = (int'(s_data.channel) < CHANNELS);
    assign ch_idx   = CH_W'(chan_reg);

    // position of the oldest slot, guarded against a stale pointer
    assign pos_old  = cst_rdata[POS_W-1:0];
    assign pos_cur  = (WIN_W'(pos_old) >= win_eff) ? '0 : pos_old;
    assign pos_inc  = WIN_W'(pos_cur) + 1'b1;
    assign pos_wrap = (pos_inc >= win_eff) ? '0 : POS_W'(pos_inc);

    // exact running sum update: drop the oldest sample, add the new one
    assign new_sum = sum_reg - SUM_W'($signed(smp_rdata)) + SUM_W'(sample_reg);
    assign sum_mag = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);

    always_comb begin
        state_next = state_reg;
        cst_we     = 1'b0;
        cst_waddr  = ch_idx;
        cst_wdata  = {new_sum, pos_next_reg};
        cst_raddr  = CH_W'(s_data.channel);
        smp_we     = 1'b0;
        smp_waddr  = addr_reg;
        smp_wdata  = sample_reg;
        smp_raddr  = ADDR_W'(ch_idx) * ADDR_W'(MAX_WINDOW) + ADDR_W'(pos_cur);
        div_ctrl   = '0;
        unique case (state_reg)
            S_CLEAR: begin
                // zeroing sweep over both stores
                smp_we    = 1'b1;
                smp_waddr = clr_cnt_reg;
                smp_wdata = '0;
                if (int'(clr_cnt_reg) < CHANNELS) begin
                    cst_we    = 1'b1;
                    cst_waddr = CH_W'(clr_cnt_reg);
                    cst_wdata = '0;
                end
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = in_range ? S_CHAN : S_DONE;
                end
            end
            S_CHAN: begin
                state_next = S_SAMP;
            end
            S_SAMP: begin
                smp_we          = 1'b1;
                cst_we          = 1'b1;
                div_ctrl.start  = 1'b1;
                div_ctrl.negate = new_sum[SUM_W-1];
                state_next      = S_DIV;
            end
            S_DIV: begin
                if (!div_busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
        // a window write restarts the sweep
        if (cfg_wr_en) begin
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            window_reg  <= CFG_W'(MIN_WINDOW);
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                window_reg  <= cfg_wr_data;
                clr_cnt_reg <= '0;
            end else if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            chan_reg     <= s_data.channel;
            sample_reg   <= s_data.sample;
            in_range_reg <= in_range;
        end
        if (state_reg == S_CHAN) begin
            sum_reg      <= $signed(cst_rdata[CST_W-1:POS_W]);
            pos_next_reg <= pos_wrap;
            addr_reg     <= smp_raddr;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.out_channel <= chan_reg;
            m_data_reg.average     <= in_range_reg ? div_q : '0;
        end
    end

    mma_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (CST_W),
        .AW    (CH_W)
    ) u_chan_ram (
        .aclk  (aclk),
        .we    (cst_we),
        .waddr (cst_waddr),
        .wdata (cst_wdata),
        .raddr (cst_raddr),
        .rdata (cst_rdata)
    );

    mma_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_W),
        .AW    (ADDR_W)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (smp_wdata),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    mma_divider #(
        .SUM_W (SUM_W),
        .WIN_W (WIN_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (sum_mag),
        .divisor  (win_eff),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks on the sequencer against the stores and the divider
    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider still busy while accepting a transaction");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the result cycle");

    a_store_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (smp_we || cst_we) |-> (state_reg == S_CLEAR || state_reg == S_SAMP))
        else $error("store written outside the sweep or the update cycle");

    a_update_then_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SAMP && !cfg_wr_en) |=> (state_reg == S_DIV && div_busy))
        else $error("divider not started after the store update");

endmodule
